@@ rtl/iplk_pkg.sv @@
// shared types and constants for the prefix class lookup
package iplk_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int NET_W       = 32;
    localparam int CLS_W       = 8;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic [1:0] STATUS_STORED    = 2'd0;
    localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic             mode;
        logic [NET_W-1:0] range_start;
        logic [NET_W-1:0] range_end;
        logic [CLS_W-1:0] entry_class;
        logic [NET_W-1:0] lookup_address;
    } in_word_t;

    typedef struct packed {
        logic [CLS_W-1:0] class_out;
        logic             matched;
        logic [1:0]       insert_status;
    } out_word_t;

    typedef struct packed {
        logic             valid;
        logic [NET_W-1:0] network;
        logic [CLS_W-1:0] cls;
    } cell_ent_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_RED
    } state_t;

endpackage

@@ rtl/iplk_cell.sv @@
// one table cell: holds an entry, compares against the key, shifts on insert
module iplk_cell
    import iplk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [NET_W-1:0] key,
    input  logic [CLS_W-1:0] new_class,
    input  logic             commit,
    input  cell_ent_t        prev_ent,
    input  logic             prev_le,
    input  logic             next_le,
    output cell_ent_t        ent,
    output logic             le,
    output logic             dup,
    output logic             hit,
    output logic [CLS_W-1:0] hit_class
);

    logic             valid_reg;
    logic             valid_next;
    logic [NET_W-1:0] net_reg;
    logic [NET_W-1:0] net_next;
    logic [CLS_W-1:0] cls_reg;
    logic [CLS_W-1:0] cls_next;
    logic             le_reg;
    logic             eq_reg;
    logic             cov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            le_reg    <= 1'b0;
            eq_reg    <= 1'b0;
            cov_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            le_reg    <= valid_reg && (net_reg <= key);
            eq_reg    <= valid_reg && (net_reg == key);
            cov_reg   <= (key & net_reg) == net_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        net_reg <= net_next;
        cls_reg <= cls_next;
    end

    // an empty cell counts as above the key, so the insert point is the first cell not below
    always_comb
    begin
        valid_next = valid_reg;
        net_next   = net_reg;
        cls_next   = cls_reg;
        if (commit && !le_reg)
        begin
            if (prev_le)
            begin
                valid_next = 1'b1;
                net_next   = key;
                cls_next   = new_class;
            end
            else
            begin
                valid_next = prev_ent.valid;
                net_next   = prev_ent.network;
                cls_next   = prev_ent.cls;
            end
        end
    end

    assign ent.valid   = valid_reg;
    assign ent.network = net_reg;
    assign ent.cls     = cls_reg;
    assign le          = le_reg;
    assign dup         = eq_reg;
    // predecessor is the last cell at or below the key
    assign hit         = le_reg && !next_le && cov_reg;
    assign hit_class   = hit ? cls_reg : '0;

endmodule

@@ rtl/iplk_reduce.sv @@
// or-reduction of the per-cell duplicate and hit flags and of the hit classes
module iplk_reduce
    import iplk_pkg::*;
(
    input  logic [TABLE_DEPTH-1:0] dup_vec,
    input  logic [TABLE_DEPTH-1:0] hit_vec,
    input  logic [CLS_W-1:0]       cls_vec [TABLE_DEPTH],
    output logic                   any_dup,
    output logic                   any_hit,
    output logic [CLS_W-1:0]       hit_cls
);

    always_comb
    begin
        hit_cls = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit_cls = hit_cls | cls_vec[i];
        end
    end

    assign any_dup = |dup_vec;
    assign any_hit = |hit_vec;

endmodule

@@ rtl/ip_prefix_class_lookup.sv @@
// top level: sorted network table in a row of cells with predecessor prefix match
// the word is registered on accept, the cells compare it, and done and result are registered from the reduce state
// a new word can be accepted in the reduce state; busy is high only in the compare cycle
// the cells register their compares in the compare state and the flags are or-reduced in the next
// reset empties the table at once and sets default_class to zero
// results cannot be stalled: done is high for exactly one cycle per word
module ip_prefix_class_lookup
    import iplk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_word_t         req,
    output logic             done,
    output out_word_t        result,
    input  logic             cfg_we,
    input  logic [CLS_W-1:0] cfg_wdata
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CLS_W-1:0] default_class_reg;
    logic             op_reg;
    logic [NET_W-1:0] key_reg;
    logic [CLS_W-1:0] cls_reg;
    logic             done_reg;
    logic             done_next;
    out_word_t        result_reg;
    out_word_t        result_next;

    logic             accept;
    logic             commit;
    logic             full;
    logic             any_dup;
    logic             any_hit;
    logic [CLS_W-1:0] hit_cls;

    cell_ent_t              ent [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] le_vec;
    logic [TABLE_DEPTH-1:0] dup_vec;
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [CLS_W-1:0]       cls_vec [TABLE_DEPTH];

    assign busy   = (state_reg == ST_CMP);
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(TABLE_DEPTH));
    assign commit = (state_reg == ST_RED) && (op_reg == MODE_INSERT) && !any_dup && !full;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            cell_ent_t prev_ent;
            logic      prev_le;
            logic      next_le;
            if (g == 0)
            begin : g_first
                assign prev_ent = '0;
                assign prev_le  = 1'b1;
            end
            else
            begin : g_mid
                assign prev_ent = ent[g-1];
                assign prev_le  = le_vec[g-1];
            end
            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign next_le = 1'b0;
            end
            else
            begin : g_notlast
                assign next_le = le_vec[g+1];
            end
            iplk_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .key       (key_reg),
                .new_class (cls_reg),
                .commit    (commit),
                .prev_ent  (prev_ent),
                .prev_le   (prev_le),
                .next_le   (next_le),
                .ent       (ent[g]),
                .le        (le_vec[g]),
                .dup       (dup_vec[g]),
                .hit       (hit_vec[g]),
                .hit_class (cls_vec[g])
            );
        end
    endgenerate

    iplk_reduce u_reduce (
        .dup_vec (dup_vec),
        .hit_vec (hit_vec),
        .cls_vec (cls_vec),
        .any_dup (any_dup),
        .any_hit (any_hit),
        .hit_cls (hit_cls)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            count_reg         <= '0;
            default_class_reg <= '0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (commit)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cfg_we)
            begin
                default_class_reg <= cfg_wdata;
            end
        end
    end

    // the key is the network on insert and the address on lookup
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.mode;
            key_reg <= (req.mode == MODE_INSERT) ? (req.range_start & req.range_end)
                                                 : req.lookup_address;
            cls_reg <= req.entry_class;
        end
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_RED;
            end
            ST_RED:
            begin
                state_next = accept ? ST_CMP : ST_IDLE;
                done_next  = 1'b1;
                if (op_reg == MODE_INSERT)
                begin
                    result_next.class_out = '0;
                    result_next.matched   = 1'b0;
                    if (any_dup)
                    begin
                        result_next.insert_status = STATUS_DUPLICATE;
                    end
                    else if (full)
                    begin
                        result_next.insert_status = STATUS_FULL;
                    end
                    else
                    begin
                        result_next.insert_status = STATUS_STORED;
                    end
                end
                else
                begin
                    result_next.class_out     = any_hit ? hit_cls : default_class_reg;
                    result_next.matched       = any_hit;
                    result_next.insert_status = STATUS_STORED;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_done_after_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_RED))
        else $error("result strobe without a reduce cycle");

    a_one_predecessor: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("more than one cell claims the predecessor");

    a_insert_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.insert_status != STATUS_STORED) |-> !result.matched)
        else $error("insert result flagged as a match");

    a_commit_grows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("stored insert did not grow the table");

endmodule

@@ sim/ip_prefix_class_lookup_tb.sv @@
// testbench for the prefix class lookup: random and directed words checked against a table model
`timescale 1ns / 1ps

module ip_prefix_class_lookup_tb;
    import iplk_pkg::*;

    class prefix_class_board;
        logic [NET_W-1:0] nets [TABLE_DEPTH];
        logic [CLS_W-1:0] classes [TABLE_DEPTH];
        int unsigned      held;
        logic [CLS_W-1:0] fallback_class;
        out_word_t        due_words [$];
        int unsigned      bad_words;

        function new();
            held = 0;
            fallback_class = '0;
            bad_words = 0;
        endfunction

        function void set_fallback(logic [CLS_W-1:0] value);
            fallback_class = value;
        endfunction

        // entries are ascending, so this is the index one past the predecessor
        function int unsigned count_at_or_below(logic [NET_W-1:0] key);
            int unsigned n;
            n = 0;
            while (n < held && nets[n] <= key)
                n++;
            return n;
        endfunction

        function void note_word(in_word_t w);
            out_word_t        o;
            logic [NET_W-1:0] net;
            int unsigned      pos;
            int unsigned      i;
            o = '0;
            if (w.mode == MODE_INSERT)
            begin
                net = w.range_start & w.range_end;
                pos = count_at_or_below(net);
                if (pos > 0 && nets[pos-1] == net)
                    o.insert_status = STATUS_DUPLICATE;
                else if (held >= TABLE_DEPTH)
                    o.insert_status = STATUS_FULL;
                else
                begin
                    for (i = held; i > pos; i--)
                    begin
                        nets[i] = nets[i-1];
                        classes[i] = classes[i-1];
                    end
                    nets[pos] = net;
                    classes[pos] = w.entry_class;
                    held++;
                    o.insert_status = STATUS_STORED;
                end
            end
            else
            begin
                pos = count_at_or_below(w.lookup_address);
                o.class_out = fallback_class;
                // only the predecessor is tried, never an earlier entry
                if (pos > 0 && (w.lookup_address & nets[pos-1]) == nets[pos-1])
                begin
                    o.class_out = classes[pos-1];
                    o.matched = 1'b1;
                end
            end
            due_words.push_back(o);
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (due_words.size() == 0)
            begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected result word: class %0d matched %0b status %0d",
                             got.class_out, got.matched, got.insert_status);
                return;
            end
            want = due_words.pop_front();
            if (got.class_out !== want.class_out || got.matched !== want.matched ||
                got.insert_status !== want.insert_status)
            begin
                bad_words++;
                if (bad_words <= 10)
                    $display("result mismatch at %0t: class %0d/%0d matched %0b/%0b status %0d/%0d",
                             $realtime, got.class_out, want.class_out, got.matched,
                             want.matched, got.insert_status, want.insert_status);
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    in_word_t         req = '0;
    logic             done;
    out_word_t        result;
    logic             cfg_we = 1'b0;
    logic [CLS_W-1:0] cfg_wdata = '0;

    prefix_class_board board;
    logic [NET_W-1:0]  sent_nets [$];
    int                idle_pct = 0;

    ip_prefix_class_lookup uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                board.set_fallback(cfg_wdata);
            if (done)
                board.check_word(result);
            if (start && !busy)
                board.note_word(req);
        end
    end

    // called at a rising edge; returns at the edge that accepts the word
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= w;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    task automatic send_insert(input logic [NET_W-1:0] first, input logic [NET_W-1:0] last,
                               input logic [CLS_W-1:0] cls);
        in_word_t w;
        w.mode = MODE_INSERT;
        w.range_start = first;
        w.range_end = last;
        w.entry_class = cls;
        w.lookup_address = $urandom;
        sent_nets.push_back(first & last);
        send_word(w);
    endtask

    task automatic send_lookup(input logic [NET_W-1:0] addr);
        in_word_t w;
        w.mode = MODE_LOOKUP;
        w.range_start = $urandom;
        w.range_end = $urandom;
        w.entry_class = CLS_W'($urandom);
        w.lookup_address = addr;
        send_word(w);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (board.due_words.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_default(input logic [CLS_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int idle);
        int               k;
        int               len;
        int               pick;
        logic [NET_W-1:0] mask;
        logic [NET_W-1:0] base;
        logic [NET_W-1:0] net;
        bit               do_insert;
        idle_pct = idle;
        for (k = 0; k < count; k++)
        begin
            // lean on inserts until the table has filled
            if (board.held < TABLE_DEPTH)
                do_insert = $urandom_range(99) < 65;
            else
                do_insert = $urandom_range(99) < 40;
            pick = $urandom_range(99);
            if (do_insert)
            begin
                if (pick < 75 || sent_nets.size() == 0)
                begin
                    len = $urandom_range(32);
                    mask = (len == 0) ? '0 : ({NET_W{1'b1}} << (NET_W - len));
                    base = $urandom & mask;
                    send_insert(base, base | ~mask, CLS_W'($urandom));
                end
                else if (pick < 90)
                begin
                    // same network again with different host bits in the end address
                    net = sent_nets[$urandom_range(sent_nets.size() - 1)];
                    send_insert(net, net | $urandom, CLS_W'($urandom));
                end
                else
                    send_insert($urandom, $urandom, CLS_W'($urandom));
            end
            else
            begin
                if (sent_nets.size() == 0 || pick < 40)
                    send_lookup($urandom);
                else
                begin
                    net = sent_nets[$urandom_range(sent_nets.size() - 1)];
                    if (pick < 60)
                        send_lookup(net);
                    else
                        send_lookup(net | ($urandom >> $urandom_range(8, 32)));
                end
            end
            if ($urandom_range(59) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial
    begin
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_default(8'hC3);
        idle_pct = 20;
        // empty table gives the default class
        send_lookup(32'h0000_0000);
        send_lookup(32'hFFFF_FFFF);
        send_insert(32'h0A00_0000, 32'h0AFF_FFFF, 8'h11);
        // repeated network keeps the first class
        send_insert(32'h0A00_0000, 32'h0A00_FFFF, 8'h22);
        send_lookup(32'h0A01_0203);
        // nothing stored at or below
        send_lookup(32'h09FF_FFFF);
        send_insert(32'h0A01_0000, 32'h0A01_FFFF, 8'h33);
        // predecessor does not cover the address, earlier /8 not tried
        send_lookup(32'h0A02_0000);
        send_lookup(32'h0A01_ABCD);
        send_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'hFFFF_FFFE);
        send_insert(32'h0000_0000, 32'hFFFF_FFFF, 8'h5A);
        send_lookup(32'h0500_0000);
        send_lookup(32'h0000_0000);
        send_insert(32'hC0A8_0100, 32'hC0A8_01FF, 8'h00);
        send_lookup(32'hC0A8_01FE);
        drain_results();

        write_default(8'h00);
        run_phase(200, 33);
        write_default(CLS_W'($urandom_range(1, 254)));
        run_phase(200, 80);
        write_default(8'hFF);
        run_phase(200, 0);

        if (board.bad_words == 0 && board.due_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
